@@ hw/rtl/npbr_pkg.sv @@
// Shared types, opcode constants and decode helpers for the next-PC branch resolver.
package npbr_pkg;

  localparam int unsigned WORD_W = 32;

  // Top nibble of a long instruction word.
  localparam logic [3:0] TOP_REL24 = 4'hf;
  localparam logic [3:0] TOP_CMP   = 4'hb;

  // Top nibble of a short slot.
  localparam logic [3:0] SLOT_REL8 = 4'h7;
  localparam logic [3:0] SLOT_MISC = 4'h1;

  // Relative branch kinds.
  localparam logic [3:0] BR_BC   = 4'h8;
  localparam logic [3:0] BR_BNC  = 4'h9;
  localparam logic [3:0] BR_BCL  = 4'hc;
  localparam logic [3:0] BR_BNCL = 4'hd;
  localparam logic [3:0] BR_BL   = 4'he;
  localparam logic [3:0] BR_BRA  = 4'hf;

  // Compare branch kinds.
  localparam logic [3:0] CMP_EQ   = 4'h0;
  localparam logic [3:0] CMP_NE   = 4'h1;
  localparam logic [3:0] CMP_EQZ  = 4'h8;
  localparam logic [3:0] CMP_NEZ  = 4'h9;
  localparam logic [3:0] CMP_LTZ  = 4'ha;
  localparam logic [3:0] CMP_GEZ  = 4'hb;
  localparam logic [3:0] CMP_LEZ  = 4'hc;
  localparam logic [3:0] CMP_GTZ  = 4'hd;

  // Register jump and return sub-codes within a short slot.
  localparam logic [3:0] SUB_RTE_B = 4'h0;
  localparam logic [3:0] SUB_RTE_C = 4'hd;
  localparam logic [3:0] SUB_JMP_C = 4'hc;
  localparam logic [3:0] JMP_JC    = 4'hc;
  localparam logic [3:0] JMP_JNC   = 4'hd;
  localparam logic [3:0] JMP_JL    = 4'he;
  localparam logic [3:0] JMP_JMP   = 4'hf;

  localparam int unsigned IN_TDATA_W  = 200;
  localparam int unsigned OUT_TDATA_W = 32;

  typedef struct packed {
    logic [WORD_W-1:0] insn_word;
    logic [WORD_W-1:0] current_pc;
    logic              cond_bit;
    logic [WORD_W-1:0] return_pc;
    logic [WORD_W-1:0] cmp_left_value;
    logic [WORD_W-1:0] cmp_right_value;
    logic [WORD_W-1:0] jump_reg_value;
  } npbr_item_t;

  typedef struct packed {
    logic [WORD_W-1:0] next_address;
    logic              kernel_target;
  } npbr_result_t;

  function automatic logic branch_taken(input logic [3:0] kind, input logic cond);
    logic taken;
    case (kind) inside
      BR_BNC, BR_BNCL: taken = ~cond;
      BR_BC, BR_BCL:   taken = cond;
      BR_BL, BR_BRA:   taken = 1'b1;
      default:         taken = 1'b0;
    endcase
    return taken;
  endfunction

  function automatic logic compare_taken(input logic [3:0] kind, input logic [WORD_W-1:0] left,
                                         input logic [WORD_W-1:0] right);
    logic neg;
    logic zero;
    logic taken;
    neg  = right[WORD_W-1];
    zero = (right == '0);
    unique case (kind)
      CMP_EQ:  taken = (left == right);
      CMP_NE:  taken = (left != right);
      CMP_EQZ: taken = zero;
      CMP_NEZ: taken = ~zero;
      CMP_LTZ: taken = neg;
      CMP_GEZ: taken = ~neg;
      CMP_LEZ: taken = neg | zero;
      CMP_GTZ: taken = ~neg & ~zero;
      default: taken = 1'b0;
    endcase
    return taken;
  endfunction

endpackage

@@ hw/rtl/npbr_resolve.sv @@
// Combinational decode of one instruction into the address of the next one.
module npbr_resolve (
  input  npbr_pkg::npbr_item_t   item,
  output npbr_pkg::npbr_result_t result
);
  import npbr_pkg::*;

  logic [WORD_W-1:0] w;
  logic [WORD_W-1:0] pc;
  logic [WORD_W-1:0] pc_al;
  logic [WORD_W-1:0] tgt24;
  logic [WORD_W-1:0] tgt16;
  logic [WORD_W-1:0] tgt8;
  logic [WORD_W-1:0] step4;
  logic [WORD_W-1:0] step_seq;
  logic [15:0]       slot;
  logic [3:0]        sa;
  logic [3:0]        sb;
  logic [3:0]        sc;
  logic              jmp_taken;
  logic [WORD_W-1:0] next_addr;

  assign w     = item.insn_word;
  assign pc    = item.current_pc;
  assign pc_al = {pc[WORD_W-1:2], 2'b00};

  assign tgt24 = pc_al + {{6{w[23]}}, w[23:0], 2'b00};
  assign tgt16 = pc_al + {{14{w[15]}}, w[15:0], 2'b00};

  // Any nonzero low address bit selects the right slot, whose top bit reads as zero.
  assign slot = (pc[1:0] != 2'b00) ? {1'b0, w[14:0]} : w[31:16];
  assign sa   = slot[15:12];
  assign sb   = slot[11:8];
  assign sc   = slot[7:4];
  assign tgt8 = pc_al + {{22{slot[7]}}, slot[7:0], 2'b00};

  assign step4    = pc + 32'd4;
  assign step_seq = w[15] ? step4 : (pc + 32'd2);

  assign jmp_taken = (sc == SUB_JMP_C) &&
                     (((sb == JMP_JC) && item.cond_bit) || ((sb == JMP_JNC) && !item.cond_bit) ||
                      (sb == JMP_JL) || (sb == JMP_JMP));

  always_comb begin
    next_addr = step_seq;
    if (w[31]) begin
      next_addr = step4;
      if ((w[31:28] == TOP_REL24) && branch_taken(w[27:24], item.cond_bit)) begin
        next_addr = tgt24;
      end else if ((w[31:28] == TOP_CMP) &&
                   compare_taken(w[23:20], item.cmp_left_value, item.cmp_right_value)) begin
        next_addr = tgt16;
      end
    end else if (sa == SLOT_REL8) begin
      if (branch_taken(sb, item.cond_bit)) begin
        next_addr = tgt8;
      end
    end else if (sa == SLOT_MISC) begin
      if ((sb == SUB_RTE_B) && (sc == SUB_RTE_C)) begin
        next_addr = item.return_pc;
      end else if (jmp_taken) begin
        next_addr = item.jump_reg_value;
      end
    end
  end

  assign result.next_address  = next_addr;
  assign result.kernel_target = next_addr[WORD_W-1];

endmodule

@@ hw/rtl/next_pc_branch_resolver.sv @@
// Top level of the next-PC branch resolver: input register, decode and result register.
// A transaction passes the input register, then the result register, which drives out_tvalid.
// Throughput: one transaction per cycle unless out_tready stalls; the input register and the
// result register form a two-stage pipeline; each stage advances when the next is empty or drains.
// Reset: rst_n (synchronous, active low) empties both stages; the data registers are not reset.
module next_pc_branch_resolver (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // [31:0] insn_word, [63:32] current_pc, [64] cond_bit, [96:65] return_pc,
  // [128:97] cmp_left_value, [160:129] cmp_right_value, [192:161] jump_reg_value, rest zero
  input  logic [npbr_pkg::IN_TDATA_W-1:0]      in_tdata,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // [31:0] next_address
  output logic [npbr_pkg::OUT_TDATA_W-1:0]     out_tdata,
  // [0] kernel_target
  output logic                                 out_tuser
);
  import npbr_pkg::*;

  npbr_item_t   in_item;
  npbr_item_t   s1_item_r;
  npbr_item_t   s1_item_nxt;
  logic         s1_valid_r;
  logic         s1_valid_nxt;
  npbr_result_t res;
  npbr_result_t out_res_r;
  npbr_result_t out_res_nxt;
  logic         out_valid_r;
  logic         out_valid_nxt;
  logic         s2_ready;
  logic         in_fire;

  assign in_item.insn_word       = in_tdata[31:0];
  assign in_item.current_pc      = in_tdata[63:32];
  assign in_item.cond_bit        = in_tdata[64];
  assign in_item.return_pc       = in_tdata[96:65];
  assign in_item.cmp_left_value  = in_tdata[128:97];
  assign in_item.cmp_right_value = in_tdata[160:129];
  assign in_item.jump_reg_value  = in_tdata[192:161];

  assign s2_ready  = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || s2_ready;
  assign in_fire   = in_tvalid && in_tready;

  npbr_resolve u_resolve (
    .item   (s1_item_r),
    .result (res)
  );

  always_comb begin
    s1_item_nxt   = s1_item_r;
    s1_valid_nxt  = s1_valid_r;
    out_res_nxt   = out_res_r;
    out_valid_nxt = out_valid_r;
    if (s2_ready) begin
      out_res_nxt   = res;
      out_valid_nxt = s1_valid_r;
    end
    if (in_tready) begin
      s1_item_nxt  = in_item;
      s1_valid_nxt = in_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_item_r <= s1_item_nxt;
    out_res_r <= out_res_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_res_r.next_address;
  assign out_tuser  = out_res_r.kernel_target;

  // An accepted transaction always occupies the input stage on the next cycle.
  a_in_lands: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> s1_valid_r)
    else $error("accepted transaction did not reach the input stage");

  // A held input stage must keep its contents while the result stage is blocked.
  a_s1_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s2_ready) |=> (s1_valid_r && $stable(s1_item_r)))
    else $error("input stage lost or changed a waiting transaction");

  // A full input stage moves into the result stage whenever that stage can take it.
  a_s1_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && s2_ready) |=> out_valid_r)
    else $error("transaction dropped between stages");

  // The kernel flag is the top bit of the resolved address.
  a_kernel_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_res_r.kernel_target == out_res_r.next_address[WORD_W-1]))
    else $error("kernel flag disagrees with next address");

endmodule
